>>> rtl/core/gcm_pkg.sv
`timescale 1ns / 1ps

package gcm_pkg;

  localparam int DATA_W     = 32;
  localparam int PERIOD_W   = 10;
  localparam int WINDOW_LEN = 5;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10);

  // Product of a 33-bit heading change and the zero-extended period.
  localparam int PROD_W = DATA_W + 1 + PERIOD_W + 1;

  // The window sum and its magnitude plus the rounding offset.
  localparam int SUM_W = DATA_W + $clog2(WINDOW_LEN);
  localparam int HALF  = WINDOW_LEN / 2;

  // Division by the window length: multiply by a truncated reciprocal, then
  // fix the quotient, which can fall short by a few counts.
  localparam int          RECIP_SHIFT = 32;
  localparam logic [31:0] RECIP       = 32'((64'd1 << RECIP_SHIFT) / WINDOW_LEN);
  localparam int          RPROD_W     = SUM_W + 32;
  localparam int          CORR_STEPS  = WINDOW_LEN / 2 + 1;
  localparam int          REM_W       = $clog2(WINDOW_LEN * (CORR_STEPS + 1));
  localparam int          CNT_W       = $clog2(CORR_STEPS + 1);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return DATA_W'(hi);
    end else if (v < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(v);
  endfunction

endpackage

>>> rtl/core/gcm_if.sv
`timescale 1ns / 1ps

interface gcm_sample_if;
  import gcm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] heading_sample;
  logic signed [DATA_W-1:0] gyro_rate;
  modport source (output valid, heading_sample, gyro_rate, input ready);
  modport sink (input valid, heading_sample, gyro_rate, output ready);
endinterface

interface gcm_result_if;
  import gcm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] compass_rate;
  logic signed [DATA_W-1:0] mean_mismatch;
  logic signed [DATA_W-1:0] mismatch_slope;
  logic signed [DATA_W-1:0] mismatch_curvature;
  modport source (output valid, compass_rate, mean_mismatch, mismatch_slope,
                  mismatch_curvature, input ready);
  modport sink (input valid, compass_rate, mean_mismatch, mismatch_slope,
                mismatch_curvature, output ready);
endinterface

interface gcm_cfg_if;
  import gcm_pkg::*;
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] inverse_period;
  modport source (output valid, inverse_period, input ready);
  modport sink (input valid, inverse_period, output ready);
endinterface

>>> rtl/core/gyro_compass_mismatch_monitor_unit.sv
`timescale 1ns / 1ps

// Gyro and compass mismatch monitor.
// The sample channel takes one word per cycle holding a compass heading and a
// gyro rate, both signed Q16.16. The result channel returns one word per
// sample: the compass rate, the mean of the last five mismatches (compass rate
// minus gyro rate), and the first and second differences of that mean.
// The cfg channel writes the inverse sample period; it is always ready and
// should only be written while no samples are in flight.
// While the receiver keeps up, a sample is accepted every cycle; its result
// passes through the nine-register pipeline: input register, period multiply,
// saturation, window sum, reciprocal multiply, remainder, quotient fix-up,
// then the two difference stages.
// When the receiver stalls, the whole pipeline holds and the sample channel
// drops ready until the result word is taken; nothing is lost or repeated.
// Reset clears the pipeline, the previous heading, the window, the previous
// mean and slope, and sets the inverse period to ten.
module gyro_compass_mismatch_monitor_unit (
  input logic          clk,
  input logic          rst,
  gcm_sample_if.sink   sample,
  gcm_cfg_if.sink      cfg,
  gcm_result_if.source result
);
  import gcm_pkg::*;

  logic                     adv;

  logic [PERIOD_W-1:0]      inverse_period;
  logic signed [DATA_W-1:0] last_heading;
  logic signed [DATA_W-1:0] mismatch_window [WINDOW_LEN];
  logic signed [DATA_W-1:0] last_mean;
  logic signed [DATA_W-1:0] last_slope;

  logic                     a_valid, b_valid, c_valid, d_valid, e_valid;
  logic                     f_valid, g_valid, h_valid, o_valid;

  logic signed [DATA_W-1:0] a_heading, a_gyro;
  logic signed [PROD_W-1:0] b_prod;
  logic signed [DATA_W-1:0] b_gyro;
  logic signed [DATA_W-1:0] c_rate, c_mis;
  logic signed [SUM_W-1:0]  d_sum;
  logic signed [DATA_W-1:0] d_rate;
  logic [SUM_W-1:0]         e_x;
  logic [RPROD_W-1:0]       e_prod;
  logic                     e_neg;
  logic signed [DATA_W-1:0] e_rate;
  logic [DATA_W-1:0]        f_q0;
  logic [REM_W-1:0]         f_r;
  logic                     f_neg;
  logic signed [DATA_W-1:0] f_rate;
  logic signed [DATA_W-1:0] g_mean, g_rate;
  logic signed [DATA_W-1:0] h_mean, h_slope, h_rate;
  logic signed [DATA_W-1:0] o_rate, o_mean, o_slope, o_curve;

  logic signed [DATA_W:0]   diff_next;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [DATA_W-1:0] rate_next, mis_next;
  logic signed [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]         mag_next, x_next;
  logic [RPROD_W-1:0]       rprod_next;
  logic [DATA_W-1:0]        q0_next;
  logic [SUM_W-1:0]         r_next;
  logic [CNT_W-1:0]         corr_next;
  logic [DATA_W-1:0]        q_next;
  logic signed [DATA_W:0]   smean_next;
  logic signed [DATA_W-1:0] mean_next, slope_next, curve_next;

  assign adv          = !o_valid || result.ready;
  assign sample.ready = adv;
  assign cfg.ready    = 1'b1;

  assign result.valid              = o_valid;
  assign result.compass_rate       = o_rate;
  assign result.mean_mismatch      = o_mean;
  assign result.mismatch_slope     = o_slope;
  assign result.mismatch_curvature = o_curve;

  always_comb begin
    diff_next = {a_heading[DATA_W-1], a_heading} - {last_heading[DATA_W-1], last_heading};
    prod_next = $signed({{(PROD_W-DATA_W-1){diff_next[DATA_W]}}, diff_next})
              * $signed({{(PROD_W-PERIOD_W){1'b0}}, inverse_period});

    rate_next = sat32(64'(b_prod));
    mis_next  = sat32(64'(rate_next) - 64'(b_gyro));

    sum_next = SUM_W'(c_mis);
    for (int k = 1; k < WINDOW_LEN; k++) begin
      sum_next = sum_next + SUM_W'(mismatch_window[k]);
    end

    mag_next   = d_sum[SUM_W-1] ? SUM_W'(-d_sum) : SUM_W'(d_sum);
    x_next     = mag_next + SUM_W'(HALF);
    rprod_next = RPROD_W'(x_next) * RPROD_W'(RECIP);

    q0_next = e_prod[RECIP_SHIFT +: DATA_W];
    r_next  = e_x - SUM_W'(q0_next) * SUM_W'(WINDOW_LEN);

    corr_next = '0;
    for (int k = 1; k <= CORR_STEPS; k++) begin
      if (f_r >= REM_W'(k * WINDOW_LEN)) begin
        corr_next = corr_next + CNT_W'(1);
      end
    end
    q_next     = f_q0 + DATA_W'(corr_next);
    smean_next = f_neg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
    mean_next  = sat32(64'(smean_next));

    slope_next = sat32(64'(g_mean) - 64'(last_mean));
    curve_next = sat32(64'(h_slope) - 64'(last_slope));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      b_valid        <= 1'b0;
      c_valid        <= 1'b0;
      d_valid        <= 1'b0;
      e_valid        <= 1'b0;
      f_valid        <= 1'b0;
      g_valid        <= 1'b0;
      h_valid        <= 1'b0;
      o_valid        <= 1'b0;
      inverse_period <= PERIOD_RESET;
      last_heading   <= '0;
      last_mean      <= '0;
      last_slope     <= '0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        mismatch_window[k] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        inverse_period <= cfg.inverse_period;
      end
      if (adv) begin
        a_valid <= sample.valid;
        b_valid <= a_valid;
        c_valid <= b_valid;
        d_valid <= c_valid;
        e_valid <= d_valid;
        f_valid <= e_valid;
        g_valid <= f_valid;
        h_valid <= g_valid;
        o_valid <= h_valid;
        if (a_valid) begin
          last_heading <= a_heading;
        end
        if (c_valid) begin
          for (int k = 1; k < WINDOW_LEN; k++) begin
            mismatch_window[k-1] <= mismatch_window[k];
          end
          mismatch_window[WINDOW_LEN-1] <= c_mis;
        end
        if (g_valid) begin
          last_mean <= g_mean;
        end
        if (h_valid) begin
          last_slope <= h_slope;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_heading <= sample.heading_sample;
      a_gyro    <= sample.gyro_rate;
      b_prod    <= prod_next;
      b_gyro    <= a_gyro;
      c_rate    <= rate_next;
      c_mis     <= mis_next;
      d_sum     <= sum_next;
      d_rate    <= c_rate;
      e_x       <= x_next;
      e_prod    <= rprod_next;
      e_neg     <= d_sum[SUM_W-1];
      e_rate    <= d_rate;
      f_q0      <= q0_next;
      f_r       <= r_next[REM_W-1:0];
      f_neg     <= e_neg;
      f_rate    <= e_rate;
      g_mean    <= mean_next;
      g_rate    <= f_rate;
      h_mean    <= g_mean;
      h_slope   <= slope_next;
      h_rate    <= g_rate;
      o_rate    <= h_rate;
      o_mean    <= h_mean;
      o_slope   <= h_slope;
      o_curve   <= curve_next;
    end
  end

endmodule

>>> tb/gyro_compass_mismatch_monitor_unit_test.sv
`timescale 1ns / 1ps

module gyro_compass_mismatch_monitor_unit_test;
  import gcm_pkg::*;

  localparam int  RANDOM_PER_PHASE = 97;
  localparam int  SETTLE_CYCLES    = 16;
  localparam int  CYCLE_LIMIT      = 400000;
  localparam logic signed [DATA_W-1:0] S32_TOP = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_BOT = 32'sh8000_0000;

  typedef struct {
    logic signed [DATA_W-1:0] heading;
    logic signed [DATA_W-1:0] gyro;
    bit                       hold_for_drain;
  } sample_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] compass_rate;
    logic signed [DATA_W-1:0] mean_mismatch;
    logic signed [DATA_W-1:0] mismatch_slope;
    logic signed [DATA_W-1:0] mismatch_curvature;
  } mismatch_word_t;

  typedef enum int {READY_ALWAYS, READY_CHOPPY, READY_LONG_STALLS} ready_mode_t;

  logic clk = 1'b0;
  logic rst;

  gcm_sample_if sample_ch ();
  gcm_cfg_if    cfg_ch ();
  gcm_result_if result_ch ();

  gyro_compass_mismatch_monitor_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .cfg    (cfg_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  sample_word_t   queued_samples[$];
  mismatch_word_t awaited_mismatch_words[$];

  logic [PERIOD_W-1:0]      model_period;
  logic signed [DATA_W-1:0] model_last_heading;
  longint                   model_window[WINDOW_LEN];
  longint                   model_last_mean;
  longint                   model_last_slope;

  logic signed [DATA_W-1:0] gen_heading;
  int queued_count   = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int error_count    = 0;
  int period_writes  = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int mode_left      = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic mismatch_word_t predict_mismatch_word(
    input logic signed [DATA_W-1:0] heading,
    input logic signed [DATA_W-1:0] gyro
  );
    longint rate;
    longint mismatch;
    longint window_sum;
    longint magnitude;
    longint mean;
    longint slope;
    longint curve;
    mismatch_word_t w;
    rate = clamp_s32((longint'(heading) - longint'(model_last_heading)) *
                     longint'(model_period));
    model_last_heading = heading;
    mismatch = clamp_s32(rate - longint'(gyro));
    window_sum = 0;
    for (int k = 0; k < WINDOW_LEN - 1; k++) begin
      model_window[k] = model_window[k + 1];
      window_sum += model_window[k];
    end
    model_window[WINDOW_LEN - 1] = mismatch;
    window_sum += mismatch;
    magnitude = (window_sum < 0) ? -window_sum : window_sum;
    magnitude = (magnitude + WINDOW_LEN / 2) / WINDOW_LEN;
    mean = clamp_s32((window_sum < 0) ? -magnitude : magnitude);
    slope = clamp_s32(mean - model_last_mean);
    model_last_mean = mean;
    curve = clamp_s32(slope - model_last_slope);
    model_last_slope = slope;
    w.compass_rate       = DATA_W'(rate);
    w.mean_mismatch      = DATA_W'(mean);
    w.mismatch_slope     = DATA_W'(slope);
    w.mismatch_curvature = DATA_W'(curve);
    return w;
  endfunction

  task automatic queue_sample(input logic signed [DATA_W-1:0] heading,
                              input logic signed [DATA_W-1:0] gyro,
                              input bit hold_for_drain);
    sample_word_t s;
    s.heading        = heading;
    s.gyro           = gyro;
    s.hold_for_drain = hold_for_drain;
    queued_samples.push_back(s);
    queued_count++;
    gen_heading = heading;
  endtask

  // Most samples follow a slowly turning heading; the rest cover the full range.
  task automatic queue_random_sample(input bit hold_for_drain);
    int kind;
    int step;
    logic signed [DATA_W-1:0] heading;
    logic signed [DATA_W-1:0] gyro;
    kind = $urandom_range(0, 9);
    step = int'($urandom_range(0, 131072)) - 65536;
    if (kind <= 5) begin
      heading = gen_heading + step;
      gyro    = step * int'(model_period) + int'($urandom_range(0, 8192)) - 4096;
    end else if (kind <= 7) begin
      heading = $urandom;
      gyro    = $urandom;
    end else if (kind == 8) begin
      heading = $urandom_range(0, 1) ? S32_TOP : S32_BOT;
      gyro    = $urandom_range(0, 1) ? S32_TOP : S32_BOT;
    end else begin
      heading = ($urandom_range(0, 1) ? S32_TOP : S32_BOT) + step;
      gyro    = ($urandom_range(0, 1) ? S32_TOP : S32_BOT) - step;
    end
    queue_sample(heading, gyro, hold_for_drain);
  endtask

  task automatic wait_until_drained();
    while (accepted_count != queued_count || awaited_mismatch_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_inverse_period(input logic [PERIOD_W-1:0] value);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.inverse_period <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    model_period = value;
    period_writes++;
  endtask

  task automatic compare_field(input string name,
                               input logic signed [DATA_W-1:0] expected_value,
                               input logic signed [DATA_W-1:0] actual_value);
    if (actual_value !== expected_value) begin
      $error("%s: expected %0d, got %0d", name, expected_value, actual_value);
      error_count++;
    end
  endtask

  // Sender: bursts of words with random gaps, holding a word until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid          <= 1'b0;
      sample_ch.heading_sample <= '0;
      sample_ch.gyro_rate      <= '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        awaited_mismatch_words.push_back(
          predict_mismatch_word(sample_ch.heading_sample, sample_ch.gyro_rate));
        accepted_count++;
      end
      if (sample_ch.valid && !sample_ch.ready) begin
        sample_ch.valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        sample_ch.valid <= 1'b0;
      end else if (queued_samples.size() != 0 &&
                   (!queued_samples[0].hold_for_drain ||
                    awaited_mismatch_words.size() == 0)) begin
        sample_ch.valid          <= 1'b1;
        sample_ch.heading_sample <= queued_samples[0].heading;
        sample_ch.gyro_rate      <= queued_samples[0].gyro;
        void'(queued_samples.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each taken word and stalls on a pattern of its own.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_mismatch_words.size() == 0) begin
          $error("result word with no sample waiting for it");
          error_count++;
        end else begin
          mismatch_word_t w;
          w = awaited_mismatch_words.pop_front();
          compare_field("compass_rate", w.compass_rate, result_ch.compass_rate);
          compare_field("mean_mismatch", w.mean_mismatch, result_ch.mean_mismatch);
          compare_field("mismatch_slope", w.mismatch_slope, result_ch.mismatch_slope);
          compare_field("mismatch_curvature", w.mismatch_curvature,
                        result_ch.mismatch_curvature);
          checked_count++;
        end
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (ready_mode)
          READY_CHOPPY: begin
            if ($urandom_range(0, 3) == 0) begin
              stall_left = $urandom_range(0, 2);
              result_ch.ready <= 1'b0;
            end else begin
              result_ch.ready <= 1'b1;
            end
          end
          READY_LONG_STALLS: begin
            if ($urandom_range(0, 11) == 0) begin
              stall_left = $urandom_range(3, 20);
              result_ch.ready <= 1'b0;
            end else begin
              result_ch.ready <= 1'b1;
            end
          end
          default: begin
            result_ch.ready <= 1'b1;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [PERIOD_W-1:0] periods[$];
    rst                      <= 1'b1;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.inverse_period    <= '0;
    model_period       = PERIOD_RESET;
    model_last_heading = '0;
    model_last_mean    = 0;
    model_last_slope   = 0;
    gen_heading        = '0;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      model_window[k] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values first, then full-scale heading jumps and gyro extremes.
    queue_sample(32'sd0, 32'sd0, 1'b0);
    queue_sample(S32_TOP, 32'sd0, 1'b0);
    queue_sample(S32_BOT, 32'sd0, 1'b0);
    queue_sample(S32_BOT, S32_BOT, 1'b0);
    queue_sample(S32_BOT, S32_TOP, 1'b0);
    queue_sample(-32'sd1, -32'sd1, 1'b0);
    queue_sample(32'sd1, 32'sd1, 1'b0);
    queue_sample(32'sh0001_0000, 32'sh000A_0000, 1'b0);
    // A steady heading makes the mismatch the negated gyro rate, for rounding.
    queue_sample(32'sh0001_0000, 32'sd2, 1'b0);
    queue_sample(32'sh0001_0000, 32'sd1, 1'b0);
    queue_sample(32'sh0001_0000, -32'sd3, 1'b0);
    queue_sample(32'sh0001_0000, -32'sd4, 1'b0);
    queue_sample(32'sh0001_0000, 32'sd7, 1'b0);
    // A window full of positive limits, then of negative ones.
    for (int k = 0; k < WINDOW_LEN; k++) begin
      queue_sample(32'sh0001_0000, S32_BOT, 1'b0);
    end
    for (int k = 0; k < WINDOW_LEN; k++) begin
      queue_sample(32'sh0001_0000, S32_TOP, 1'b0);
    end
    wait_until_drained();

    periods = '{10'd1023, 10'd0, 10'd1, 10'd1000, 10'd10, 10'd0, 10'd1023};
    for (int k = 0; k < 3; k++) begin
      periods.push_back(PERIOD_W'($urandom_range(1, 1000)));
    end
    foreach (periods[p]) begin
      write_inverse_period(periods[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        queue_random_sample(n == 40 || $urandom_range(0, 49) == 0);
      end
      wait_until_drained();
    end

    $display("Checked %0d result words from %0d samples over %0d inverse period settings.",
             checked_count, accepted_count, period_writes + 1);
    $display("Stimulus mixed slow turns, full-range and saturating samples under stalls.");
    if (error_count == 0 && checked_count == accepted_count) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/gcm_pkg.sv
rtl/core/gcm_if.sv
rtl/core/gyro_compass_mismatch_monitor_unit.sv
tb/gyro_compass_mismatch_monitor_unit_test.sv
